// File: sv/scs_pkg.sv
// Shared types and constants of the sparse coordinate store.
package scs_pkg;

	// Operation codes carried in the func field
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_SET = 1'b1;

	// Magnitude bits of a double; both signed zeros clear them
	localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

	// Width of the reported entry count
	localparam int unsigned COUNT_W = 7;

	// Status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic        func;
		logic [15:0] row_index;
		logic [15:0] col_index;
		logic [63:0] entry_value;
	} scs_req_t;

	typedef struct packed {
		logic [63:0]        read_value;
		logic               hit;
		logic [COUNT_W-1:0] entry_count;
		logic               status;
	} scs_rsp_t;

endpackage

// File: sv/scs_mem.sv
// Entry table storage: key and value arrays, one write port, one registered read port.
module scs_mem import scs_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int KEY_W = 32
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [KEY_W-1:0]            wr_key,
	input  logic [63:0]                 wr_value,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	output logic [KEY_W-1:0]            rd_key,
	output logic [63:0]                 rd_value
);

	logic [KEY_W-1:0] key_mem [CAPACITY];
	logic [63:0]      value_mem [CAPACITY];

	// Write key and value together
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= wr_key;
			value_mem[wr_addr] <= wr_value;
		end
	end

	// Register read data
	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_value <= value_mem[rd_addr];
	end

endmodule

// File: sv/scs_ctrl.sv
// Request sequencer: sorted scan with a shared key comparator, then update, shift or insert.
module scs_ctrl import scs_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  scs_req_t                              req,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output scs_rsp_t                              res,
	output logic                                  wr_en,
	output logic [$clog2(CAPACITY)-1:0]           wr_addr,
	output logic [2*COORD_BITS-1:0]               wr_key,
	output logic [63:0]                           wr_value,
	output logic [$clog2(CAPACITY)-1:0]           rd_addr,
	input  logic [2*COORD_BITS-1:0]               rd_key,
	input  logic [63:0]                           rd_value
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int KEY_W  = 2 * COORD_BITS;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SCAN = 7'b0000010,
		ST_ACT  = 7'b0000100,
		ST_DEL  = 7'b0001000,
		ST_INS  = 7'b0010000,
		ST_PUT  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] p_q;
	logic [CNT_W-1:0] pos_q;
	logic [KEY_W-1:0] key_q;
	logic [63:0]      val_q;
	logic [63:0]      rv_q;
	logic             func_q;
	logic             zero_q;
	logic             found_q;
	logic             status_q;

	logic [31:0]      row_w, col_w, cnt_w;
	logic [KEY_W-1:0] key_in;
	logic [CNT_W-1:0] p_inc, p_dec, pos_inc, cnt_dec;
	logic             key_less, scan_stop, is_get, is_del, is_upd, is_full;

	// Mask coordinates to COORD_BITS and pack the key
	assign row_w  = {16'b0, req.row_index};
	assign col_w  = {16'b0, req.col_index};
	assign key_in = {row_w[COORD_BITS-1:0], col_w[COORD_BITS-1:0]};

	assign p_inc   = p_q + CNT_W'(1);
	assign p_dec   = p_q - CNT_W'(1);
	assign pos_inc = pos_q + CNT_W'(1);
	assign cnt_dec = count_q - CNT_W'(1);

	// Shared comparator for the scan
	assign key_less  = rd_key < key_q;
	assign scan_stop = (p_q >= count_q) || !key_less;

	// Decode the operation once the slot is known
	assign is_get  = (func_q == FUNC_GET);
	assign is_del  = !is_get && zero_q;
	assign is_upd  = !is_get && !zero_q && found_q;
	assign is_full = (count_q == CNT_W'(CAPACITY));

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);

	assign cnt_w = 32'(count_q);
	assign res.read_value  = rv_q;
	assign res.hit         = found_q;
	assign res.entry_count = cnt_w[COUNT_W-1:0];
	assign res.status      = status_q;

	// Drive memory ports and pick the next state
	always_comb begin
		state_d  = state_q;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = pos_q[ADDR_W-1:0];
		wr_key   = key_q;
		wr_value = val_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = p_inc[ADDR_W-1:0];
				if (scan_stop) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				priority if (is_get) begin
					state_d = ST_FIN;
				end else if (is_del) begin
					rd_addr = pos_inc[ADDR_W-1:0];
					state_d = found_q ? ST_DEL : ST_FIN;
				end else if (is_upd) begin
					wr_en   = 1'b1;
					state_d = ST_FIN;
				end else if (is_full) begin
					state_d = ST_FIN;
				end else begin
					rd_addr = cnt_dec[ADDR_W-1:0];
					state_d = (pos_q == count_q) ? ST_PUT : ST_INS;
				end
			end
			ST_DEL: begin
				rd_addr = p_inc[ADDR_W-1:0];
				if (p_q >= count_q) begin
					state_d = ST_FIN;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = p_dec[ADDR_W-1:0];
					wr_key   = rd_key;
					wr_value = rd_value;
				end
			end
			ST_INS: begin
				rd_addr  = p_dec[ADDR_W-1:0];
				wr_en    = 1'b1;
				wr_addr  = p_inc[ADDR_W-1:0];
				wr_key   = rd_key;
				wr_value = rd_value;
				if (p_q == pos_q) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DEL && p_q >= count_q) begin
				count_q <= cnt_dec;
			end else if (state_q == ST_PUT) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Hold request fields, scan pointer and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q  <= key_in;
				val_q  <= req.entry_value;
				func_q <= req.func;
				zero_q <= (req.entry_value & MAG_MASK) == 64'd0;
				p_q    <= '0;
			end
			ST_SCAN: begin
				if (scan_stop) begin
					pos_q   <= p_q;
					found_q <= (p_q < count_q) && (rd_key == key_q);
					rv_q    <= rd_value;
				end else begin
					p_q <= p_inc;
				end
			end
			ST_ACT: begin
				status_q <= STATUS_DONE;
				priority if (is_get) begin
					rv_q <= found_q ? rv_q : 64'd0;
				end else if (is_del) begin
					rv_q <= 64'd0;
					p_q  <= pos_inc;
				end else if (is_upd) begin
					rv_q <= val_q;
				end else if (is_full) begin
					rv_q     <= 64'd0;
					status_q <= STATUS_FULL;
				end else begin
					rv_q <= val_q;
					p_q  <= cnt_dec;
				end
			end
			ST_DEL: begin
				p_q <= p_inc;
			end
			ST_INS: begin
				p_q <= p_dec;
			end
			ST_PUT, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// Count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1)
		|| count_q == $past(count_q) - CNT_W'(1)))
		else $error("entry count jumped");

	// Scan pointer never passes the entry count
	a_scan_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> p_q <= count_q)
		else $error("scan pointer past count");

	// No table write while idle or scanning
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_SCAN) |-> !wr_en)
		else $error("table write outside update phase");

	// Handing off a result returns the sequencer to idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> state_q == ST_IDLE)
		else $error("sequencer not idle after result");

endmodule

// File: sv/sparse_coordinate_store_unit.sv
// Top level of the sparse coordinate store: sequencer, entry table and result register.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   scs_req_t (func, row, col, value)
//   rsp      out        rsp_valid / rsp_ready   scs_rsp_t (value, hit, count, status)
//
// The sequencer takes one request at a time: it accepts a new request only when idle,
// after the last result has gone to the output register. The time to finish grows with
// the stop position of the scan, and for an insert or delete with the entry count.
// The single table read port sets this: the sorted scan reads one entry a cycle and
// an insert or delete then moves one entry a cycle.
// Reset clears the entry count; the table needs no clearing pass.
// A finished result waits in the output register while the next request runs; a
// second result holds the sequencer until that register drains.
module sparse_coordinate_store_unit import scs_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int COORD_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  scs_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output scs_rsp_t rsp
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int KEY_W  = 2 * COORD_BITS;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [KEY_W-1:0]  wr_key, rd_key;
	logic [63:0]       wr_value, rd_value;
	logic              res_valid, res_ready;
	scs_rsp_t          res;
	logic              rsp_valid_q;
	scs_rsp_t          rsp_q;

	scs_ctrl #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_value  (wr_value),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_value  (rd_value)
	);

	scs_mem #(
		.CAPACITY (CAPACITY),
		.KEY_W    (KEY_W)
	) u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_value (wr_value),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	// Take a result when the output register is empty or draining
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	// Hold the result item until taken
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: test/sparse_coordinate_store_unit_tb.sv
// Self-checking testbench for the sparse coordinate store: directed and random get/set traffic.
import scs_pkg::*;

// Expected-result tracking: mirrors the sorted entry table and queues one answer per request
class entry_table_scoreboard #(int DEPTH = 64);
	bit [31:0] keys [DEPTH];
	bit [63:0] vals [DEPTH];
	int unsigned live_entries;
	scs_rsp_t pending_answers [$];
	int unsigned mismatches;
	int unsigned requests_seen;
	int unsigned gets_seen;
	int unsigned sets_seen;
	int unsigned hits_seen;
	int unsigned deletes_done;
	int unsigned inserts_done;
	int unsigned full_drops;
	int unsigned peak_entries;

	task report(string msg);
		mismatches++;
		if (mismatches <= 20)
			$display("MISMATCH: %s", msg);
	endtask

	// Apply one accepted request to the mirror table and queue its answer
	function void note_request(scs_req_t r);
		bit [31:0] key;
		int unsigned pos;
		bit found;
		scs_rsp_t want;
		key = {r.row_index, r.col_index};
		pos = 0;
		while (pos < live_entries && keys[pos] < key)
			pos++;
		found = (pos < live_entries) && (keys[pos] == key);
		want = '0;
		want.hit = found;
		want.read_value = found ? vals[pos] : 64'd0;
		want.status = STATUS_DONE;
		requests_seen++;
		if (found)
			hits_seen++;
		if (r.func == FUNC_SET) begin
			sets_seen++;
			if ((r.entry_value & MAG_MASK) == 64'd0) begin
				// Either signed zero removes the entry; close the gap
				if (found) begin
					for (int i = pos; i + 1 < live_entries; i++) begin
						keys[i] = keys[i + 1];
						vals[i] = vals[i + 1];
					end
					live_entries--;
					deletes_done++;
				end
				want.read_value = 64'd0;
			end else if (found) begin
				vals[pos] = r.entry_value;
				want.read_value = r.entry_value;
			end else if (live_entries >= DEPTH) begin
				// Table full: drop the insert and flag it
				want.status = STATUS_FULL;
				want.read_value = 64'd0;
				full_drops++;
			end else begin
				// Open a slot in sorted position
				for (int i = live_entries; i > pos; i--) begin
					keys[i] = keys[i - 1];
					vals[i] = vals[i - 1];
				end
				keys[pos] = key;
				vals[pos] = r.entry_value;
				live_entries++;
				inserts_done++;
				want.read_value = r.entry_value;
			end
		end else begin
			gets_seen++;
		end
		if (live_entries > peak_entries)
			peak_entries = live_entries;
		want.entry_count = live_entries[COUNT_W-1:0];
		pending_answers.push_back(want);
	endfunction

	// Compare one result against the oldest queued answer
	task check_response(scs_rsp_t got);
		scs_rsp_t want;
		if (pending_answers.size() == 0) begin
			report($sformatf("result with no request pending: value %h count %0d",
				got.read_value, got.entry_count));
			return;
		end
		want = pending_answers.pop_front();
		if (got.read_value !== want.read_value)
			report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
		if (got.hit !== want.hit)
			report($sformatf("hit %b, expected %b", got.hit, want.hit));
		if (got.entry_count !== want.entry_count)
			report($sformatf("entry_count %0d, expected %0d", got.entry_count, want.entry_count));
		if (got.status !== want.status)
			report($sformatf("status %b, expected %b", got.status, want.status));
	endtask
endclass

module sparse_coordinate_store_unit_tb;
	localparam int TABLE_DEPTH = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 600;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_AFTER = 60;

	localparam logic [63:0] PLUS_ZERO = 64'h0000_0000_0000_0000;
	localparam logic [63:0] MINUS_ZERO = 64'h8000_0000_0000_0000;
	localparam logic [63:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_POINT_ZERO = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] PLUS_INF = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] TINY_NEG = 64'h8000_0000_0000_0001;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_OPEN} traffic_mix_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	scs_req_t req;
	logic rsp_valid;
	logic rsp_ready;
	scs_rsp_t rsp;

	entry_table_scoreboard #(TABLE_DEPTH) sb;
	bit calm;
	bit long_hold_done;
	logic [15:0] row_pool [12];
	logic [15:0] col_pool [8];

	sparse_coordinate_store_unit #(
		.CAPACITY(TABLE_DEPTH),
		.COORD_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Record accepted items on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	// Receiver: random stall bursts, one long hold-off to back up the block
	initial begin
		rsp_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!long_hold_done && sb.requests_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no progress for %0d cycles", STALL_LIMIT);
		$display("sparse_coordinate_store_unit_tb NOT OK");
		$finish;
	end

	function automatic scs_req_t make_request(logic func, logic [15:0] row, logic [15:0] col,
			logic [63:0] value);
		scs_req_t r;
		r.func = func;
		r.row_index = row;
		r.col_index = col;
		r.entry_value = value;
		return r;
	endfunction

	function automatic logic [63:0] random_nonzero();
		logic [63:0] v;
		case ($urandom_range(7))
			0: v = QUIET_NAN;
			1: v = ALL_ONES;
			2: v = TINY_NEG;
			3: v = PLUS_INF;
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// Draw one random request; the mix decides how often entries are added or removed
	function automatic scs_req_t random_request(traffic_mix_t mix);
		int roll;
		int wide_pct;
		int set_cut;
		int del_cut;
		logic [15:0] row;
		logic [15:0] col;
		logic [63:0] value;
		logic func;
		roll = $urandom_range(99);
		case (mix)
			MIX_FILL: begin set_cut = 85; del_cut = 92; wide_pct = 10; end
			MIX_DRAIN: begin set_cut = 20; del_cut = 65; wide_pct = 10; end
			default: begin set_cut = 40; del_cut = 60; wide_pct = 50; end
		endcase
		if ($urandom_range(99) < wide_pct) begin
			row = 16'($urandom_range(16'hFFFF));
			col = 16'($urandom_range(16'hFFFF));
		end else begin
			row = row_pool[$urandom_range(11)];
			col = col_pool[$urandom_range(7)];
		end
		if (roll < set_cut) begin
			func = FUNC_SET;
			value = random_nonzero();
		end else if (roll < del_cut) begin
			func = FUNC_SET;
			value = $urandom_range(1) ? MINUS_ZERO : PLUS_ZERO;
		end else begin
			func = FUNC_GET;
			value = {$urandom, $urandom};
		end
		return make_request(func, row, col, value);
	endfunction

	// Offer one item, after an optional idle burst, and hold it until accepted
	task automatic offer_request(scs_req_t item);
		int gap;
		gap = (!calm && $urandom_range(3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	// Pause the sender until every queued answer has arrived
	task automatic wait_for_answers();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_answers.size() != 0);
	endtask

	task automatic run_random(traffic_mix_t mix, int count);
		for (int i = 0; i < count; i++)
			offer_request(random_request(mix));
	endtask

	initial begin
		sb = new();
		calm = 1'b0;
		long_hold_done = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;

		// Coordinate pools with both extremes so the random part hits often
		row_pool[0] = 16'h0000;
		row_pool[1] = 16'hFFFF;
		col_pool[0] = 16'h0000;
		col_pool[1] = 16'hFFFF;
		for (int i = 2; i < 12; i++)
			row_pool[i] = 16'($urandom_range(16'hFFFF));
		for (int i = 2; i < 8; i++)
			col_pool[i] = 16'($urandom_range(16'hFFFF));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, corner coordinates, overwrite, both zeros, odd patterns
		offer_request(make_request(FUNC_GET, 16'h0000, 16'h0000, ALL_ONES));
		offer_request(make_request(FUNC_SET, 16'h0000, 16'h0000, PLUS_ZERO));
		offer_request(make_request(FUNC_SET, 16'h0000, 16'h0000, ONE_POINT_ZERO));
		offer_request(make_request(FUNC_SET, 16'hFFFF, 16'hFFFF, ALL_ONES));
		offer_request(make_request(FUNC_SET, 16'h0000, 16'hFFFF, TINY_NEG));
		offer_request(make_request(FUNC_SET, 16'hFFFF, 16'h0000, QUIET_NAN));
		offer_request(make_request(FUNC_SET, 16'h0001, 16'h0002, {$urandom, $urandom}));
		offer_request(make_request(FUNC_SET, 16'h8000, 16'h0001, PLUS_INF));
		offer_request(make_request(FUNC_SET, 16'h0001, 16'h8000, 64'h0000_0000_0000_0001));
		offer_request(make_request(FUNC_GET, 16'hFFFF, 16'hFFFF, PLUS_ZERO));
		offer_request(make_request(FUNC_GET, 16'h0000, 16'hFFFF, MINUS_ZERO));
		offer_request(make_request(FUNC_SET, 16'h0000, 16'h0000, 64'hC000_0000_0000_0000));
		offer_request(make_request(FUNC_GET, 16'h0000, 16'h0000, PLUS_ZERO));
		offer_request(make_request(FUNC_GET, 16'h0005, 16'h0005, PLUS_ZERO));
		offer_request(make_request(FUNC_SET, 16'hFFFF, 16'h0000, MINUS_ZERO));
		offer_request(make_request(FUNC_SET, 16'h0000, 16'hFFFF, PLUS_ZERO));
		offer_request(make_request(FUNC_SET, 16'hFFFF, 16'h0000, PLUS_ZERO));
		offer_request(make_request(FUNC_GET, 16'hFFFF, 16'h0000, ALL_ONES));
		offer_request(make_request(FUNC_GET, 16'h0001, 16'h8000, ALL_ONES));
		offer_request(make_request(FUNC_GET, 16'h8000, 16'h0001, PLUS_ZERO));
		offer_request(make_request(FUNC_SET, 16'h0001, 16'h0002, MINUS_ZERO));
		offer_request(make_request(FUNC_GET, 16'h0001, 16'h0002, PLUS_ZERO));
		wait_for_answers();

		// Random: fill past capacity, drain, then open traffic with no idling
		run_random(MIX_FILL, 170);
		wait_for_answers();
		run_random(MIX_DRAIN, 130);
		wait_for_answers();
		calm = 1'b1;
		run_random(MIX_OPEN, 100);
		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.pending_answers.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_answers.size()));
		$display("covered %0d requests: %0d gets, %0d sets, %0d hits, peak of %0d entries",
			sb.requests_seen, sb.gets_seen, sb.sets_seen, sb.hits_seen, sb.peak_entries);
		$display("inserts %0d, deletes %0d, inserts dropped on a full table %0d, mismatches %0d",
			sb.inserts_done, sb.deletes_done, sb.full_drops, sb.mismatches);
		if (sb.mismatches == 0)
			$display("sparse_coordinate_store_unit_tb OK");
		else
			$display("sparse_coordinate_store_unit_tb NOT OK");
		$finish;
	end
endmodule
